>>> src/u8d_pkg.sv
// shared types, status codes and constants for the utf-8 validating decoder
// no dependencies; imported by every module of the block
package u8d_pkg;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BAD_CONT = 3'd3;
  localparam logic [2:0] ST_OVERLONG = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;

  // field widths and port packing
  localparam int CP_W        = 21;
  localparam int STATUS_W    = 3;
  localparam int ERR_OFS_W   = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CP_W - ERR_OFS_W;
  localparam int DEFAULT_OFFSET_BITS = 32;

  // scalar value limits
  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

  // sequence state of fixed width
  typedef struct packed {
    logic [CP_W-1:0] partial_value;
    logic [1:0]      bytes_left;
    logic [1:0]      sequence_extra;
    logic            pending_bad_cont;
    logic            dropping;
  } seq_state_t;

  // one result item
  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic [STATUS_W-1:0]  status;
    logic [ERR_OFS_W-1:0] error_offset;
    logic                 final_result;
  } result_t;

  // smallest value allowed for a form with the given number of extra bytes
  function automatic logic [CP_W-1:0] min_for_extra(input logic [1:0] extra);
    logic [CP_W-1:0] m;
    case (extra)
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      2'd3:    m = 21'h010000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> src/u8d_step_logic.sv
// per-byte decode step: next sequence state and the optional result item
// depends on u8d_pkg
module u8d_step_logic #(
  parameter int OFFSET_BITS = u8d_pkg::DEFAULT_OFFSET_BITS
) (
  input  logic [7:0]             data_byte,
  input  logic                   end_of_stream,
  input  u8d_pkg::seq_state_t    st,
  input  logic [OFFSET_BITS-1:0] seq_start,
  input  logic [OFFSET_BITS-1:0] byte_cnt,
  input  logic [OFFSET_BITS-1:0] pend_off,
  output u8d_pkg::seq_state_t    st_nxt,
  output logic [OFFSET_BITS-1:0] seq_start_nxt,
  output logic [OFFSET_BITS-1:0] byte_cnt_nxt,
  output logic [OFFSET_BITS-1:0] pend_off_nxt,
  output logic                   res_valid,
  output u8d_pkg::result_t       res
);
  import u8d_pkg::*;

  logic [2:0]             status;
  logic [OFFSET_BITS-1:0] eoff;
  logic [ERR_OFS_W-1:0]   eoff32;
  logic                   done_ok;
  logic [1:0]             extra;
  logic [1:0]             left_new;
  logic [CP_W-1:0]        pv_new;

  // reported offset is the low bits of the offset counter
  if (OFFSET_BITS >= ERR_OFS_W) begin : g_ofs_wide
    assign eoff32 = eoff[ERR_OFS_W-1:0];
  end else begin : g_ofs_narrow
    assign eoff32 = {{(ERR_OFS_W-OFFSET_BITS){1'b0}}, eoff};
  end

  assign pv_new   = {st.partial_value[CP_W-7:0], data_byte[5:0]};
  assign left_new = st.bytes_left - 2'd1;

  // classify the byte and update the sequence
  always_comb begin
    st_nxt        = st;
    seq_start_nxt = seq_start;
    pend_off_nxt  = pend_off;
    byte_cnt_nxt  = byte_cnt + OFFSET_BITS'(1);
    status        = ST_OK;
    eoff          = '0;
    done_ok       = 1'b0;
    extra         = 2'd0;
    res_valid     = 1'b0;
    res           = '0;

    if (st.dropping) begin
      if (end_of_stream) begin
        st_nxt        = '0;
        seq_start_nxt = '0;
        pend_off_nxt  = '0;
        byte_cnt_nxt  = '0;
      end
    end else begin
      if (st.bytes_left == 2'd0) begin
        // lead byte expected
        if (!data_byte[7]) begin
          st_nxt.partial_value = {{(CP_W-8){1'b0}}, data_byte};
          done_ok = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          st_nxt.partial_value = {{(CP_W-5){1'b0}}, data_byte[4:0]};
          extra = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          st_nxt.partial_value = {{(CP_W-4){1'b0}}, data_byte[3:0]};
          extra = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          st_nxt.partial_value = {{(CP_W-3){1'b0}}, data_byte[2:0]};
          extra = 2'd3;
        end else begin
          status = ST_BAD_LEAD;
          eoff   = byte_cnt;
        end
        if (extra != 2'd0) begin
          seq_start_nxt           = byte_cnt;
          st_nxt.bytes_left       = extra;
          st_nxt.sequence_extra   = extra;
          st_nxt.pending_bad_cont = 1'b0;
          pend_off_nxt            = '0;
          if (end_of_stream) begin
            status = ST_TRUNC;
            eoff   = byte_cnt;
          end
        end
      end else begin
        // continuation byte; a bad one is remembered until completion
        if (data_byte[7:6] != 2'b10 && !st.pending_bad_cont) begin
          st_nxt.pending_bad_cont = 1'b1;
          pend_off_nxt            = byte_cnt;
        end
        st_nxt.partial_value = pv_new;
        st_nxt.bytes_left    = left_new;
        if (left_new == 2'd0) begin
          if (st_nxt.pending_bad_cont) begin
            status = ST_BAD_CONT;
            eoff   = pend_off_nxt;
          end else if (pv_new < min_for_extra(st.sequence_extra)) begin
            status = ST_OVERLONG;
            eoff   = seq_start;
          end else if (pv_new > MAX_SCALAR || (pv_new >= SURR_LO && pv_new <= SURR_HI)) begin
            status = ST_INVALID;
            eoff   = seq_start;
          end else begin
            done_ok = 1'b1;
          end
        end else if (end_of_stream) begin
          status = ST_TRUNC;
          eoff   = seq_start;
        end
      end

      // build the result and finish the state update
      if (status != ST_OK) begin
        res_valid        = 1'b1;
        res.status       = status;
        res.error_offset = eoff32;
        res.final_result = 1'b1;
        if (end_of_stream) begin
          st_nxt        = '0;
          seq_start_nxt = '0;
          pend_off_nxt  = '0;
          byte_cnt_nxt  = '0;
        end else begin
          st_nxt.dropping = 1'b1;
        end
      end else if (done_ok) begin
        res_valid               = 1'b1;
        res.code_point          = st_nxt.partial_value;
        res.final_result        = end_of_stream;
        st_nxt.partial_value    = '0;
        st_nxt.sequence_extra   = 2'd0;
        st_nxt.pending_bad_cont = 1'b0;
        pend_off_nxt            = '0;
        if (end_of_stream) begin
          st_nxt        = '0;
          seq_start_nxt = '0;
          pend_off_nxt  = '0;
          byte_cnt_nxt  = '0;
        end
      end
    end
  end

endmodule

>>> src/u8d_result_reg.sv
// output register holding one result item until the sink takes it
// depends on u8d_pkg
module u8d_result_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  u8d_pkg::result_t res_in,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output u8d_pkg::result_t res_out
);
  import u8d_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign space_ok  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  // never overwrite a result the sink has not taken
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // a loaded result is offered next cycle with its payload
  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (valid_r && data_r == $past(res_in)))
    else $error("loaded result not presented");

endmodule

>>> src/utf8_validating_decoder_core.sv
// top level of the utf-8 validating decoder: input register, sequence state,
// decode step and result register; depends on u8d_pkg, u8d_step_logic, u8d_result_reg
//
//  channel  | ports     | contents
//  ---------+-----------+-------------------------------------------------------
//  input    | in_t*     | tdata: data_byte[7:0]; tlast: end_of_stream
//  result   | out_t*    | tdata: code_point, error_offset, zero pad; tuser: status;
//           |           | tlast: final_result
//
// one byte is taken every cycle while the result register has space; a result is
// offered once its byte has passed the input register and been loaded into the
// result register. the clock is set by the state update path: lead/continuation
// compares, the 21-bit shift and range checks and the offset counter increment.
// reset clears the sequence state, counters and both valid flags. when out_tready is
// low the result register holds, the input register holds one more byte, and then
// in_tready falls.
module utf8_validating_decoder_core #(
  parameter int OFFSET_BITS = u8d_pkg::DEFAULT_OFFSET_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [u8d_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0]
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  output logic [u8d_pkg::OUT_TDATA_W-1:0] out_tdata,  // code_point[20:0], error_offset[52:21], pad
  output logic [u8d_pkg::STATUS_W-1:0]    out_tuser,  // status[2:0]
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready
);
  import u8d_pkg::*;

  // input register
  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_eos_r;

  // sequence state
  seq_state_t             st_r, st_nxt;
  logic [OFFSET_BITS-1:0] seq_start_r, seq_start_nxt;
  logic [OFFSET_BITS-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [OFFSET_BITS-1:0] pend_off_r, pend_off_nxt;

  logic    step_valid;
  result_t step_res;
  logic    space_ok;
  logic    adv;
  result_t res_out;

  assign adv       = s1_valid_r && space_ok;
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata[7:0];
      s1_eos_r  <= in_tlast;
    end
  end

  // sequence state, updated as each byte leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      seq_start_r <= '0;
      byte_cnt_r  <= '0;
      pend_off_r  <= '0;
    end else if (adv) begin
      st_r        <= st_nxt;
      seq_start_r <= seq_start_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      pend_off_r  <= pend_off_nxt;
    end
  end

  u8d_step_logic #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .data_byte     (s1_byte_r),
    .end_of_stream (s1_eos_r),
    .st            (st_r),
    .seq_start     (seq_start_r),
    .byte_cnt      (byte_cnt_r),
    .pend_off      (pend_off_r),
    .st_nxt        (st_nxt),
    .seq_start_nxt (seq_start_nxt),
    .byte_cnt_nxt  (byte_cnt_nxt),
    .pend_off_nxt  (pend_off_nxt),
    .res_valid     (step_valid),
    .res           (step_res)
  );

  u8d_result_reg u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && step_valid),
    .res_in    (step_res),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_out)
  );

  // pack the result ports
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_out.error_offset, res_out.code_point};
  assign out_tuser = res_out.status;
  assign out_tlast = res_out.final_result;

  // bytes after an error give nothing
  a_drop_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_r.dropping) |-> !step_valid)
    else $error("result produced while dropping");

  // an error result always ends the stream and carries no code point
  a_err_final : assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && step_res.status != ST_OK) |-> (step_res.final_result
                                                  && step_res.code_point == '0))
    else $error("error result not final");

  // end of stream clears the offset counter and sequence state
  a_eos_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_eos_r) |=> (byte_cnt_r == '0 && st_r == '0))
    else $error("state not cleared at end of stream");

endmodule
